// ----- rtl/core/bounded_sorted_list_engine_core_defines.svh -----
// Assertion macros for the bounded sorted list engine.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef BOUNDED_SORTED_LIST_ENGINE_CORE_DEFINES_SVH
`define BOUNDED_SORTED_LIST_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSLE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/bsle_pkg.sv -----
// Types and constants for the bounded sorted list engine.
// No dependencies; imported by the core.
`default_nettype none

package bsle_pkg;

	localparam int DEPTH  = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int FUNC_W = 3;
	localparam int KEY_W  = 31;
	localparam int PAY_W  = 64;
	localparam int STAT_W = 2;
	localparam int SIZE_W = 6;

	localparam int S_TDATA_W = ((KEY_W + PAY_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((KEY_W + PAY_W + SIZE_W + 7) / 8) * 8;

	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_FRONT = 3'd0,
		FN_PUSH_ORD   = 3'd1,
		FN_PUSH_BACK  = 3'd2,
		FN_POP_FRONT  = 3'd3,
		FN_POP_KEY    = 3'd4,
		FN_POP_BACK   = 3'd5,
		FN_LOOKUP     = 3'd6,
		FN_DUMP       = 3'd7
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_EMPTY     = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_RD,
		S_CHK,
		S_LFIN,
		S_UP_RD,
		S_UP_WR,
		S_DN_RD,
		S_DN_WR,
		S_PUT,
		S_RESP
	} state_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/bounded_sorted_list_engine_core.sv -----
// Bounded sorted list engine: one entry memory with registered read, walked by a small
// sequencer (scan, shift up, shift down, report). One item at a time; it waits on a result stall.
// Push back and pop back write or drop the last entry directly; push front shifts every entry
// up; ordered push and pop by key scan first, then may shift the tail up or down; pop front
// shifts entries down; lookup and dump scan the whole list. Full and empty report directly.
// Next item accepted the cycle after the final result loads. Reset clears count and control.
`default_nettype none

`include "bounded_sorted_list_engine_core_defines.svh"

module bounded_sorted_list_engine_core
	import bsle_pkg::*;
(
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     s_tvalid,
	output logic                    s_tready,
	input  wire  [S_TDATA_W-1:0]    s_tdata,   // key, payload, zero pad
	input  wire  [FUNC_W-1:0]       s_tuser,   // func
	output logic                    m_tvalid,
	input  wire                     m_tready,
	output logic [M_TDATA_W-1:0]    m_tdata,   // out_key, out_payload, size_after, zero pad
	output logic [STAT_W-1:0]       m_tuser,   // status
	output logic                    m_tlast
);

	state_t                 state_q, state_d;
	func_t                  op_q;
	logic [KEY_W-1:0]       key_q;
	logic [PAY_W-1:0]       pay_q;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic [IDX_W-1:0]       ptr_q, ptr_d;
	logic [IDX_W-1:0]       pos_q, pos_d;
	logic                   pend_q, pend_d;
	logic [PAY_W-1:0]       pend_pay_q, pend_pay_d;
	status_t                rstat_q, rstat_d;

	entry_t                 mem_q [DEPTH];
	entry_t                 rd_q;
	logic                   mem_ren, mem_wen;
	logic [IDX_W-1:0]       mem_raddr, mem_waddr;
	entry_t                 mem_wdata;

	logic                   ovld_q, ovld_d;
	status_t                ostat_q, ostat_d;
	logic [KEY_W-1:0]       okey_q, okey_d;
	logic [PAY_W-1:0]       opay_q, opay_d;
	logic [SIZE_W-1:0]      osize_q, osize_d;
	logic                   olast_q, olast_d;
	logic                   out_ld;

	logic                   accept, out_free, last_ent, full, empty, key_hit;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !ovld_q || m_tready;
	assign last_ent = ((CNT_W'(ptr_q) + CNT_W'(1)) == cnt_q);
	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign key_hit  = (rd_q.key == key_q);

	assign m_tvalid = ovld_q;
	assign m_tuser  = ostat_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = {{(M_TDATA_W - KEY_W - PAY_W - SIZE_W){1'b0}}, osize_q, opay_q, okey_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		ptr_d      = ptr_q;
		pos_d      = pos_q;
		pend_d     = pend_q;
		pend_pay_d = pend_pay_q;
		rstat_d    = rstat_q;
		mem_ren    = 1'b0;
		mem_raddr  = ptr_q;
		mem_wen    = 1'b0;
		mem_waddr  = ptr_q;
		mem_wdata  = '{key: key_q, payload: pay_q};
		out_ld     = 1'b0;
		ostat_d    = STAT_OK;
		okey_d     = '0;
		opay_d     = '0;
		olast_d    = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				ptr_d  = '0;
				pos_d  = '0;
				pend_d = 1'b0;
				if (op_q == FN_PUSH_FRONT || op_q == FN_PUSH_ORD || op_q == FN_PUSH_BACK) begin
					if (full) begin
						rstat_d = STAT_FULL;
						state_d = S_RESP;
					end else if (empty || op_q == FN_PUSH_BACK) begin
						ptr_d   = cnt_q[IDX_W-1:0];
						state_d = S_PUT;
					end else if (op_q == FN_PUSH_FRONT) begin
						ptr_d   = cnt_q[IDX_W-1:0];
						state_d = S_UP_RD;
					end else begin
						state_d = S_RD;
					end
				end else if (empty) begin
					rstat_d = STAT_EMPTY;
					state_d = S_RESP;
				end else if (op_q == FN_POP_BACK ||
						(op_q == FN_POP_FRONT && cnt_q == CNT_W'(1))) begin
					cnt_d   = cnt_q - CNT_W'(1);
					rstat_d = STAT_OK;
					state_d = S_RESP;
				end else if (op_q == FN_POP_FRONT) begin
					state_d = S_DN_RD;
				end else begin
					state_d = S_RD;
				end
			end
			S_RD: begin
				mem_ren = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				priority case (op_q)
					FN_PUSH_ORD: begin
						if (rd_q.key < key_q) begin
							// new entry goes before the first smaller key
							pos_d   = ptr_q;
							ptr_d   = cnt_q[IDX_W-1:0];
							state_d = S_UP_RD;
						end else if (last_ent) begin
							ptr_d   = cnt_q[IDX_W-1:0];
							state_d = S_PUT;
						end else begin
							ptr_d   = ptr_q + IDX_W'(1);
							state_d = S_RD;
						end
					end
					FN_POP_KEY: begin
						if (key_hit && last_ent) begin
							cnt_d   = cnt_q - CNT_W'(1);
							rstat_d = STAT_OK;
							state_d = S_RESP;
						end else if (key_hit) begin
							state_d = S_DN_RD;
						end else if (last_ent) begin
							rstat_d = STAT_NOT_FOUND;
							state_d = S_RESP;
						end else begin
							ptr_d   = ptr_q + IDX_W'(1);
							state_d = S_RD;
						end
					end
					FN_LOOKUP: begin
						// a match is held back until the next one shows whether it is last
						if (!(key_hit && pend_q && !out_free)) begin
							if (key_hit) begin
								if (pend_q) begin
									out_ld  = 1'b1;
									okey_d  = key_q;
									opay_d  = pend_pay_q;
									olast_d = 1'b0;
								end
								pend_d     = 1'b1;
								pend_pay_d = rd_q.payload;
							end
							if (last_ent) begin
								state_d = S_LFIN;
							end else begin
								ptr_d   = ptr_q + IDX_W'(1);
								state_d = S_RD;
							end
						end
					end
					FN_DUMP: begin
						if (out_free) begin
							out_ld  = 1'b1;
							okey_d  = rd_q.key;
							opay_d  = rd_q.payload;
							olast_d = last_ent;
							if (last_ent) begin
								state_d = S_IDLE;
							end else begin
								ptr_d   = ptr_q + IDX_W'(1);
								state_d = S_RD;
							end
						end
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_LFIN: begin
				if (out_free) begin
					out_ld  = 1'b1;
					ostat_d = pend_q ? STAT_OK : STAT_NOT_FOUND;
					okey_d  = pend_q ? key_q : '0;
					opay_d  = pend_q ? pend_pay_q : '0;
					state_d = S_IDLE;
				end
			end
			S_UP_RD: begin
				mem_ren   = 1'b1;
				mem_raddr = ptr_q - IDX_W'(1);
				state_d   = S_UP_WR;
			end
			S_UP_WR: begin
				mem_wen   = 1'b1;
				mem_wdata = rd_q;
				if ((ptr_q - IDX_W'(1)) == pos_q) begin
					ptr_d   = pos_q;
					state_d = S_PUT;
				end else begin
					ptr_d   = ptr_q - IDX_W'(1);
					state_d = S_UP_RD;
				end
			end
			S_DN_RD: begin
				mem_ren   = 1'b1;
				mem_raddr = ptr_q + IDX_W'(1);
				state_d   = S_DN_WR;
			end
			S_DN_WR: begin
				mem_wen   = 1'b1;
				mem_wdata = rd_q;
				if ((CNT_W'(ptr_q) + CNT_W'(2)) == cnt_q) begin
					cnt_d   = cnt_q - CNT_W'(1);
					rstat_d = STAT_OK;
					state_d = S_RESP;
				end else begin
					ptr_d   = ptr_q + IDX_W'(1);
					state_d = S_DN_RD;
				end
			end
			S_PUT: begin
				mem_wen = 1'b1;
				cnt_d   = cnt_q + CNT_W'(1);
				rstat_d = STAT_OK;
				state_d = S_RESP;
			end
			S_RESP: begin
				if (out_free) begin
					out_ld  = 1'b1;
					ostat_d = rstat_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		ovld_d  = out_ld || (ovld_q && !m_tready);
		osize_d = SIZE_W'(cnt_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pend_q <= 1'b0;
			ovld_q <= 1'b0;
		end else begin
			cnt_q  <= cnt_d;
			pend_q <= pend_d;
			ovld_q <= ovld_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= func_t'(s_tuser);
			key_q <= s_tdata[KEY_W-1:0];
			pay_q <= s_tdata[KEY_W+PAY_W-1:KEY_W];
		end
		ptr_q      <= ptr_d;
		pos_q      <= pos_d;
		pend_pay_q <= pend_pay_d;
		rstat_q    <= rstat_d;
		if (out_ld) begin
			ostat_q <= ostat_d;
			okey_q  <= okey_d;
			opay_q  <= opay_d;
			osize_q <= osize_d;
			olast_q <= olast_d;
		end
	end

	// entry store
	always_ff @(posedge clk) begin
		if (mem_wen) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_ren) begin
			rd_q <= mem_q[mem_raddr];
		end
	end

	`BSLE_ASSERT_SAME(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(DEPTH), "entry count beyond depth")
	`BSLE_ASSERT_SAME(a_mem_excl, clk, arst_n, mem_wen, !mem_ren, "entry store read and written together")
	`BSLE_ASSERT_SAME(a_out_free, clk, arst_n, out_ld, !ovld_q || m_tready, "result overwritten before taken")
	`BSLE_ASSERT_NEXT(a_accept_dec, clk, arst_n, accept, state_q == S_DEC, "accepted item not decoded")
	`BSLE_ASSERT_NEXT(a_cnt_step, clk, arst_n, 1'b1,
		cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + CNT_W'(1) ||
		cnt_q + CNT_W'(1) == $past(cnt_q), "entry count jumped")

endmodule

`default_nettype wire

// ----- bench/bounded_sorted_list_engine_core_tb.sv -----
// Self-checking bench for bounded_sorted_list_engine_core: drives list commands on the input
// stream, predicts every result item with its own list model and checks the output stream.
// Depends on bsle_pkg and the core RTL only.
module bounded_sorted_list_engine_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bsle_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int SETTLE_CYCLES = 4 * DEPTH + 16;
	localparam int S_PAD_W       = S_TDATA_W - KEY_W - PAY_W;

	typedef struct {
		status_t          st;
		logic [KEY_W-1:0] k;
		logic [PAY_W-1:0] p;
		logic [SIZE_W-1:0] sz;
		logic             fin;
	} list_result_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [FUNC_W-1:0]    s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]    m_tuser;
	logic                 m_tlast;

	// list model, updated as each item is accepted
	logic [KEY_W-1:0] list_keys [DEPTH];
	logic [PAY_W-1:0] list_pays [DEPTH];
	int               list_len = 0;

	list_result_t pending_results[$];
	int           mismatches   = 0;
	int           results_seen = 0;
	int           cycles       = 0;
	bit           steady       = 1'b0;

	bounded_sorted_list_engine_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("bounded_sorted_list_engine_core_tb failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= 24);
	end

	function automatic void expect_result(status_t st, logic [KEY_W-1:0] k,
			logic [PAY_W-1:0] p, logic fin);
		list_result_t r;
		r.st  = st;
		r.k   = k;
		r.p   = p;
		r.sz  = SIZE_W'(list_len);
		r.fin = fin;
		pending_results.push_back(r);
	endfunction

	function automatic void open_slot(int pos, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
		for (int i = list_len; i > pos; i--) begin
			list_keys[i] = list_keys[i-1];
			list_pays[i] = list_pays[i-1];
		end
		list_keys[pos] = k;
		list_pays[pos] = p;
		list_len++;
	endfunction

	function automatic void close_slot(int pos);
		for (int i = pos; i + 1 < list_len; i++) begin
			list_keys[i] = list_keys[i+1];
			list_pays[i] = list_pays[i+1];
		end
		list_len--;
	endfunction

	// apply one command to the list model and queue the results it causes
	function automatic void apply_command(func_t f, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
		int pos;
		int hits;
		if (f inside {FN_PUSH_FRONT, FN_PUSH_ORD, FN_PUSH_BACK}) begin
			if (list_len >= DEPTH) begin
				expect_result(STAT_FULL, '0, '0, 1'b1);
				return;
			end
			pos = (f == FN_PUSH_FRONT) ? 0 : list_len;
			if (f == FN_PUSH_ORD) begin
				// descending order; equal keys keep arrival order
				for (int i = 0; i < list_len; i++) begin
					if (list_keys[i] < k) begin
						pos = i;
						break;
					end
				end
			end
			open_slot(pos, k, p);
			expect_result(STAT_OK, '0, '0, 1'b1);
			return;
		end
		if (list_len == 0) begin
			expect_result(STAT_EMPTY, '0, '0, 1'b1);
			return;
		end
		case (f)
			FN_POP_FRONT: begin
				close_slot(0);
				expect_result(STAT_OK, '0, '0, 1'b1);
			end
			FN_POP_KEY: begin
				pos = -1;
				for (int i = 0; i < list_len; i++) begin
					if (list_keys[i] == k) begin
						pos = i;
						break;
					end
				end
				if (pos < 0) begin
					expect_result(STAT_NOT_FOUND, '0, '0, 1'b1);
				end else begin
					close_slot(pos);
					expect_result(STAT_OK, '0, '0, 1'b1);
				end
			end
			FN_POP_BACK: begin
				list_len--;
				expect_result(STAT_OK, '0, '0, 1'b1);
			end
			FN_LOOKUP: begin
				hits = 0;
				for (int i = 0; i < list_len; i++) begin
					if (list_keys[i] == k) begin
						expect_result(STAT_OK, list_keys[i], list_pays[i], 1'b0);
						hits++;
					end
				end
				if (hits == 0) begin
					expect_result(STAT_NOT_FOUND, '0, '0, 1'b1);
				end else begin
					pending_results[$].fin = 1'b1;
				end
			end
			default: begin
				for (int i = 0; i < list_len; i++) begin
					expect_result(STAT_OK, list_keys[i], list_pays[i], i + 1 == list_len);
				end
			end
		endcase
	endfunction

	task automatic report_mismatch(string field, logic [PAY_W-1:0] got, logic [PAY_W-1:0] want);
		$display("mismatch on %s at result %0d: got %h, want %h", field, results_seen, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", PAY_W'(m_tdata[KEY_W-1:0]), '0);
			end else begin
				want = pending_results.pop_front();
				if (m_tuser !== want.st)
					report_mismatch("status", PAY_W'(m_tuser), PAY_W'(want.st));
				if (m_tdata[KEY_W-1:0] !== want.k)
					report_mismatch("out_key", PAY_W'(m_tdata[KEY_W-1:0]), PAY_W'(want.k));
				if (m_tdata[KEY_W +: PAY_W] !== want.p)
					report_mismatch("out_payload", m_tdata[KEY_W +: PAY_W], want.p);
				if (m_tdata[KEY_W+PAY_W +: SIZE_W] !== want.sz)
					report_mismatch("size_after", PAY_W'(m_tdata[KEY_W+PAY_W +: SIZE_W]),
						PAY_W'(want.sz));
				if (m_tlast !== want.fin)
					report_mismatch("last", PAY_W'(m_tlast), PAY_W'(want.fin));
			end
			results_seen++;
		end
	end

	// leaves tvalid high after the handshake so back-to-back items need no extra edge
	task automatic send_item(func_t f, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
		while (!steady && $urandom_range(99) < 24) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= {{S_PAD_W{1'b0}}, p, k};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		apply_command(f, k, p);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// mostly keys already in the list or from a small pool, so searches hit and duplicate
	function automatic logic [KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 40 && list_len != 0)
			return list_keys[$urandom_range(list_len - 1)];
		if (r < 70)
			return KEY_W'($urandom_range(6));
		if (r < 75)
			return '1;
		return KEY_W'($urandom);
	endfunction

	task automatic test_empty_list();
		send_item(FN_POP_FRONT, '0, '0);
		send_item(FN_POP_KEY, '1, '1);
		send_item(FN_POP_BACK, '0, '0);
		send_item(FN_LOOKUP, '0, '0);
		send_item(FN_DUMP, '1, '1);
	endtask

	task automatic test_ordering_and_search();
		send_item(FN_PUSH_ORD, 31'd5, 64'h0123_4567_89ab_cdef);
		send_item(FN_PUSH_ORD, 31'd9, 64'h1111_2222_3333_4444);
		send_item(FN_PUSH_ORD, 31'd5, 64'hfedc_ba98_7654_3210);
		send_item(FN_PUSH_ORD, '0, 64'h5555_aaaa_5555_aaaa);
		send_item(FN_PUSH_ORD, '1, 64'haaaa_5555_aaaa_5555);
		send_item(FN_PUSH_FRONT, 31'd5, '1);
		send_item(FN_PUSH_BACK, 31'd5, '0);
		// hold the sender until the list is quiet
		wait_drained();
		send_item(FN_LOOKUP, 31'd5, '0);
		send_item(FN_LOOKUP, 31'd3, '0);
		send_item(FN_POP_KEY, 31'd3, '0);
		send_item(FN_POP_KEY, 31'd5, '0);
		send_item(FN_DUMP, '0, '0);
		send_item(FN_POP_FRONT, '0, '0);
		send_item(FN_POP_BACK, '0, '0);
		send_item(FN_POP_KEY, '1, '0);
		send_item(FN_DUMP, '0, '0);
	endtask

	task automatic test_fill_to_capacity();
		steady = 1'b1;
		while (list_len < DEPTH)
			send_item(func_t'($urandom_range(2)), pick_key(), {$urandom, $urandom});
		send_item(FN_PUSH_FRONT, pick_key(), {$urandom, $urandom});
		send_item(FN_PUSH_ORD, pick_key(), {$urandom, $urandom});
		send_item(FN_PUSH_BACK, pick_key(), {$urandom, $urandom});
		send_item(FN_LOOKUP, list_keys[$urandom_range(DEPTH - 1)], '0);
		send_item(FN_DUMP, '0, '0);
		steady = 1'b0;
		while (list_len > 0)
			send_item(func_t'(3 + $urandom_range(2)), pick_key(), {$urandom, $urandom});
	endtask

	task automatic test_random_traffic(int n_items);
		bit    growing;
		int    r;
		func_t f;
		growing = 1'b1;
		for (int i = 0; i < n_items; i++) begin
			if (list_len == DEPTH)
				growing = 1'b0;
			else if (list_len == 0)
				growing = 1'b1;
			else if ($urandom_range(19) == 0)
				growing = !growing;
			r = $urandom_range(99);
			if (r < 10)
				f = func_t'($urandom_range(7));
			else if (r < 25)
				f = FN_LOOKUP;
			else if (r < 30)
				f = FN_DUMP;
			else if ((r < 80) == growing)
				f = func_t'($urandom_range(2));
			else
				f = func_t'(3 + $urandom_range(2));
			send_item(f, pick_key(), {$urandom, $urandom});
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_ordering_and_search();
		test_fill_to_capacity();
		test_random_traffic(270);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("bounded_sorted_list_engine_core_tb passed");
		else
			$display("bounded_sorted_list_engine_core_tb failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/bsle_pkg.sv
rtl/core/bounded_sorted_list_engine_core.sv
bench/bounded_sorted_list_engine_core_tb.sv
